@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Defining SYNTH compiles them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, held off while reset is asserted
`define DB4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is asserted
`define DB4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DB4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define DB4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ hdl/db4dwt_pkg.sv @@
package db4dwt_pkg;

    // Data widths
    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 18;
    localparam int COEF_FRAC  = 17;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int PSUM_W     = PROD_W + 2;
    localparam int SUM_W      = PSUM_W + 1;
    localparam int OUT_W      = 25;
    localparam int IDX_W      = 11;
    localparam int HALF_W     = 12;
    localparam int LEN_W      = HALF_W + 1;

    // Filter and buffer geometry
    localparam int TAPS        = 8;
    localparam int HEAD_DEPTH  = 6;
    localparam int EXT_DEPTH   = TAPS + HEAD_DEPTH;
    localparam int PSUM_N      = 2;
    localparam int GRP         = TAPS / PSUM_N;
    localparam int DRAIN_PAIRS = 4;
    localparam int FIRST_POS   = TAPS - 1;

    // Line length limits
    localparam int MAX_HALF   = 2048;
    localparam int HALF_RESET = 8;

    // Rounding and output range
    localparam int ROUND_HALF = 2 ** (COEF_FRAC - 1);
    localparam int OUT_MAX    = 2 ** (OUT_W - 1) - 1;
    localparam int OUT_MIN    = -(2 ** (OUT_W - 1));

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [PSUM_W-1:0]   t_psum;
    typedef logic signed [SUM_W-1:0]    t_sum;
    typedef logic signed [OUT_W-1:0]    t_out;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [HALF_W-1:0]          t_half;
    typedef logic [LEN_W-1:0]           t_len;

    // Pair bookkeeping carried down the filter pipeline
    typedef struct packed {
        t_idx idx;
        logic line_end;
    } t_pair_tag;

    // db4 low-pass taps, Q1.17
    localparam t_coef COEF_LO [TAPS] = '{
        18'sd30196, 18'sd93696, 18'sd82691, -18'sd3668,
        -18'sd24515, 18'sd4042, 18'sd4310, -18'sd1389
    };

    // High-pass taps: g[k] = (-1)^k * h[7-k]
    localparam t_coef COEF_HI [TAPS] = '{
        -18'sd1389, -18'sd4310, 18'sd4042, 18'sd24515,
        -18'sd3668, -18'sd82691, 18'sd93696, -18'sd30196
    };

endpackage

@@ hdl/db4dwt_ifs.sv @@
// Sample input channel
interface db4dwt_in_if;
    logic                 valid;
    logic                 ready;
    db4dwt_pkg::t_sample  sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

// Coefficient pair output channel
interface db4dwt_out_if;
    logic               valid;
    logic               ready;
    db4dwt_pkg::t_out   approx;
    db4dwt_pkg::t_out   detail;
    db4dwt_pkg::t_idx   pair_index;
    logic               line_end;

    modport source (output valid, output approx, output detail, output pair_index,
                    output line_end, input ready);
    modport sink   (input valid, input approx, input detail, input pair_index,
                    input line_end, output ready);
endinterface

@@ hdl/db4_periodic_dwt_analysis.sv @@
// One-level db4 wavelet analysis with periodic wrap over a line of 2*half_length
// signed 24-bit samples, one sample per item. Every odd position from 7 on but the
// last yields one approx/detail pair via the tap, product, partial-sum and output
// registers; the last sample of a line yields the min(half_length, 4) wrapped pairs.
// Samples are taken one per clock while the pipe has room; the last sample holds off
// input while the wrap sequencer feeds those pairs, one per cycle while the pipe has
// room, into the single eight-tap filter bank (products, two partial sums, final sum
// with rounding). A half_length write saturates it to 1..2048 and restarts the line.
`include "assert_macros.svh"

module db4_periodic_dwt_analysis (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [db4dwt_pkg::HALF_W-1:0] i_cfg_wr_data,
    db4dwt_in_if.sink                  i_in,
    db4dwt_out_if.source               o_out
);

    // Line state
    db4dwt_pkg::t_half   r_half;
    db4dwt_pkg::t_half   r_pos;
    db4dwt_pkg::t_half   cfg_half;
    db4dwt_pkg::t_half   half_m1;
    db4dwt_pkg::t_half   pos_sub;
    db4dwt_pkg::t_len    line_len;
    db4dwt_pkg::t_sample r_head   [db4dwt_pkg::HEAD_DEPTH];
    db4dwt_pkg::t_sample head_next[db4dwt_pkg::HEAD_DEPTH];
    db4dwt_pkg::t_sample r_win    [db4dwt_pkg::TAPS];
    db4dwt_pkg::t_sample win_next [db4dwt_pkg::TAPS];
    db4dwt_pkg::t_sample r_ext    [db4dwt_pkg::EXT_DEPTH];
    db4dwt_pkg::t_sample ext_next [db4dwt_pkg::EXT_DEPTH];

    // Wrap sequencer
    logic               r_drain_busy;
    db4dwt_pkg::t_idx   r_drain_idx;
    db4dwt_pkg::t_idx   first_idx;
    logic               drain_done;

    // Input decode
    logic               acc;
    logic               last_pos;
    logic               emit_pos;
    db4dwt_pkg::t_idx   emit_idx;

    // Pipeline enables
    logic en_o;
    logic en3;
    logic en2;
    logic en1;

    // Stage 1: taps
    logic                  r_s1_valid;
    db4dwt_pkg::t_sample   r_s1_tap[db4dwt_pkg::TAPS];
    db4dwt_pkg::t_pair_tag r_s1_tag;

    // Stage 2: products
    logic                  r_s2_valid;
    db4dwt_pkg::t_prod     r_s2_pa[db4dwt_pkg::TAPS];
    db4dwt_pkg::t_prod     r_s2_pd[db4dwt_pkg::TAPS];
    db4dwt_pkg::t_pair_tag r_s2_tag;

    // Stage 3: partial sums
    logic                  r_s3_valid;
    db4dwt_pkg::t_psum     r_s3_sa[db4dwt_pkg::PSUM_N];
    db4dwt_pkg::t_psum     r_s3_sd[db4dwt_pkg::PSUM_N];
    db4dwt_pkg::t_pair_tag r_s3_tag;

    // Output register
    logic                  r_o_valid;
    db4dwt_pkg::t_out      r_o_approx;
    db4dwt_pkg::t_out      r_o_detail;
    db4dwt_pkg::t_pair_tag r_o_tag;

    // Round to nearest, ties away from zero, then clamp to the output range
    function automatic db4dwt_pkg::t_out round_sat(db4dwt_pkg::t_sum v);
        db4dwt_pkg::t_sum bias;
        db4dwt_pkg::t_sum sh;
        bias = db4dwt_pkg::t_sum'(db4dwt_pkg::ROUND_HALF)
             - db4dwt_pkg::t_sum'(v[db4dwt_pkg::SUM_W-1]);
        sh = (v + bias) >>> db4dwt_pkg::COEF_FRAC;
        if (sh > db4dwt_pkg::t_sum'(db4dwt_pkg::OUT_MAX)) begin
            return db4dwt_pkg::t_out'(db4dwt_pkg::OUT_MAX);
        end else if (sh < db4dwt_pkg::t_sum'(db4dwt_pkg::OUT_MIN)) begin
            return db4dwt_pkg::t_out'(db4dwt_pkg::OUT_MIN);
        end
        return db4dwt_pkg::t_out'(sh);
    endfunction

    // Handshake and enables; each stage moves when the one after it has room
    assign acc  = i_in.valid && i_in.ready;
    assign en_o = !r_o_valid || o_out.ready;
    assign en3  = !r_s3_valid || en_o;
    assign en2  = !r_s2_valid || en3;
    assign en1  = !r_s1_valid || en2;
    assign i_in.ready = en1 && !r_drain_busy;

    // Position decode
    assign line_len = {r_half, 1'b0};
    assign half_m1  = r_half - db4dwt_pkg::t_half'(1);
    assign last_pos = ({1'b0, r_pos} == (line_len - db4dwt_pkg::t_len'(1)));
    assign pos_sub  = r_pos - db4dwt_pkg::t_half'(db4dwt_pkg::FIRST_POS);
    assign emit_idx = pos_sub[db4dwt_pkg::HALF_W-1:1];
    assign emit_pos = r_pos[0] && (r_pos >= db4dwt_pkg::t_half'(db4dwt_pkg::FIRST_POS))
                   && !last_pos;

    // Wrap pairs start at half-4, or at 0 on short lines
    assign first_idx = (r_half >= db4dwt_pkg::t_half'(db4dwt_pkg::DRAIN_PAIRS)) ?
        db4dwt_pkg::t_idx'(r_half - db4dwt_pkg::t_half'(db4dwt_pkg::DRAIN_PAIRS)) : '0;
    assign drain_done = ({1'b0, r_drain_idx} == half_m1);

    // Saturate the written half-length to 1..MAX_HALF
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            cfg_half = db4dwt_pkg::t_half'(1);
        end else if (i_cfg_wr_data > db4dwt_pkg::t_half'(db4dwt_pkg::MAX_HALF)) begin
            cfg_half = db4dwt_pkg::t_half'(db4dwt_pkg::MAX_HALF);
        end else begin
            cfg_half = i_cfg_wr_data;
        end
    end

    // Head and window after taking the current sample
    always_comb begin
        for (int h = 0; h < db4dwt_pkg::HEAD_DEPTH; h++) begin
            head_next[h] = (r_pos == db4dwt_pkg::t_half'(h)) ? i_in.sample : r_head[h];
        end
        for (int k = 0; k < db4dwt_pkg::TAPS - 1; k++) begin
            win_next[k] = r_win[k+1];
        end
        win_next[db4dwt_pkg::TAPS-1] = i_in.sample;
    end

    // Wrap line: the tail of the line followed by its head, or the head repeated
    // with the line period when the line is shorter than eight samples
    for (genvar m = 0; m < db4dwt_pkg::EXT_DEPTH; m++) begin : g_ext
        if (m < db4dwt_pkg::TAPS) begin : g_tail
            always_comb begin
                case (r_half)
                    db4dwt_pkg::t_half'(1): ext_next[m] = head_next[m % 2];
                    db4dwt_pkg::t_half'(2): ext_next[m] = head_next[m % 4];
                    db4dwt_pkg::t_half'(3): ext_next[m] = head_next[m % 6];
                    default:                ext_next[m] = win_next[m];
                endcase
            end
        end else begin : g_head
            always_comb begin
                case (r_half)
                    db4dwt_pkg::t_half'(1): ext_next[m] = head_next[m % 2];
                    db4dwt_pkg::t_half'(2): ext_next[m] = head_next[m % 4];
                    db4dwt_pkg::t_half'(3): ext_next[m] = head_next[m % 6];
                    default:                ext_next[m] = head_next[m - db4dwt_pkg::TAPS];
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half       <= db4dwt_pkg::t_half'(db4dwt_pkg::HALF_RESET);
            r_pos        <= '0;
            r_drain_busy <= 1'b0;
            r_drain_idx  <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_s3_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            // half-length write restarts the line
            if (i_cfg_wr_en) begin
                r_half <= cfg_half;
                r_pos  <= '0;
            end else if (acc) begin
                r_pos <= last_pos ? '0 : r_pos + db4dwt_pkg::t_half'(1);
            end

            // wrap sequencer: one pair per cycle into the filter while the tap stage can move
            if (acc && last_pos) begin
                r_drain_busy <= 1'b1;
                r_drain_idx  <= first_idx;
            end else if (r_drain_busy && en1) begin
                if (drain_done) begin
                    r_drain_busy <= 1'b0;
                end else begin
                    r_drain_idx <= r_drain_idx + db4dwt_pkg::t_idx'(1);
                end
            end

            if (en1) begin
                r_s1_valid <= r_drain_busy || (acc && emit_pos);
            end
            if (en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (en_o) begin
                r_o_valid <= r_s3_valid;
            end
        end
    end

    // Sample storage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_head <= head_next;
            r_win  <= win_next;
        end
        if (acc && last_pos) begin
            r_ext <= ext_next;
        end else if (r_drain_busy && en1) begin
            for (int m = 0; m < db4dwt_pkg::EXT_DEPTH - 2; m++) begin
                r_ext[m] <= r_ext[m+2];
            end
        end
    end

    // Filter pipeline datapath
    always_ff @(posedge i_clk) begin
        // taps from the wrap line or from the sliding window
        if (en1) begin
            if (r_drain_busy) begin
                for (int k = 0; k < db4dwt_pkg::TAPS; k++) begin
                    r_s1_tap[k] <= r_ext[k];
                end
                r_s1_tag.idx      <= r_drain_idx;
                r_s1_tag.line_end <= drain_done;
            end else begin
                r_s1_tap          <= win_next;
                r_s1_tag.idx      <= emit_idx;
                r_s1_tag.line_end <= ({1'b0, emit_idx} == half_m1);
            end
        end

        // constant-coefficient products
        if (en2) begin
            for (int k = 0; k < db4dwt_pkg::TAPS; k++) begin
                r_s2_pa[k] <= db4dwt_pkg::t_prod'(r_s1_tap[k])
                            * db4dwt_pkg::t_prod'(db4dwt_pkg::COEF_LO[k]);
                r_s2_pd[k] <= db4dwt_pkg::t_prod'(r_s1_tap[k])
                            * db4dwt_pkg::t_prod'(db4dwt_pkg::COEF_HI[k]);
            end
            r_s2_tag <= r_s1_tag;
        end

        // two partial sums of four products each
        if (en3) begin
            for (int g = 0; g < db4dwt_pkg::PSUM_N; g++) begin
                r_s3_sa[g] <= db4dwt_pkg::t_psum'(r_s2_pa[db4dwt_pkg::GRP*g])
                            + db4dwt_pkg::t_psum'(r_s2_pa[db4dwt_pkg::GRP*g+1])
                            + db4dwt_pkg::t_psum'(r_s2_pa[db4dwt_pkg::GRP*g+2])
                            + db4dwt_pkg::t_psum'(r_s2_pa[db4dwt_pkg::GRP*g+3]);
                r_s3_sd[g] <= db4dwt_pkg::t_psum'(r_s2_pd[db4dwt_pkg::GRP*g])
                            + db4dwt_pkg::t_psum'(r_s2_pd[db4dwt_pkg::GRP*g+1])
                            + db4dwt_pkg::t_psum'(r_s2_pd[db4dwt_pkg::GRP*g+2])
                            + db4dwt_pkg::t_psum'(r_s2_pd[db4dwt_pkg::GRP*g+3]);
            end
            r_s3_tag <= r_s2_tag;
        end

        // final sum, rounding and clamp
        if (en_o) begin
            r_o_approx <= round_sat(db4dwt_pkg::t_sum'(r_s3_sa[0])
                                  + db4dwt_pkg::t_sum'(r_s3_sa[1]));
            r_o_detail <= round_sat(db4dwt_pkg::t_sum'(r_s3_sd[0])
                                  + db4dwt_pkg::t_sum'(r_s3_sd[1]));
            r_o_tag    <= r_s3_tag;
        end
    end

    // Output channel
    assign o_out.valid      = r_o_valid;
    assign o_out.approx     = r_o_approx;
    assign o_out.detail     = r_o_detail;
    assign o_out.pair_index = r_o_tag.idx;
    assign o_out.line_end   = r_o_tag.line_end;

    // Checks
    `DB4_ASSERT_NEXT(a_last_starts_drain, i_clk, i_rst_n, acc && last_pos,
        r_drain_busy && (r_pos == '0), "last item of a line did not start the wrap pairs")
    `DB4_ASSERT_IMPL(a_drain_blocks_input, i_clk, i_rst_n, r_drain_busy, !acc,
        "item accepted while wrap pairs are pending")
    `DB4_ASSERT_NEXT(a_drain_holds, i_clk, i_rst_n, r_drain_busy && !en1,
        r_drain_busy && $stable(r_drain_idx), "wrap sequencer moved while stalled")
    `DB4_ASSERT_NEXT(a_s1_advances, i_clk, i_rst_n, r_s1_valid && en2, r_s2_valid,
        "tap stage pair lost on its way to the product stage")

endmodule

@@ sim/db4_periodic_dwt_analysis_tb.sv @@
module db4_periodic_dwt_analysis_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_PAUSE = 12;
    localparam int CYCLE_LIMIT = 50000;
    localparam db4dwt_pkg::t_sample SMAX = 24'sh7FFFFF;
    localparam db4dwt_pkg::t_sample SMIN = 24'sh800000;

    // One approx/detail pair as the block hands it out
    typedef struct packed {
        db4dwt_pkg::t_out approx;
        db4dwt_pkg::t_out detail;
        db4dwt_pkg::t_idx idx;
        logic             line_end;
    } t_coef_pair;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [db4dwt_pkg::HALF_W-1:0] i_cfg_wr_data;

    db4dwt_in_if  in_if();
    db4dwt_out_if out_if();

    db4_periodic_dwt_analysis u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (in_if),
        .o_out         (out_if)
    );

    // Predictor state: line head, last eight samples, position, register
    longint                        head_q [db4dwt_pkg::HEAD_DEPTH];
    longint                        win_q  [db4dwt_pkg::TAPS];
    longint                        tap_sel[db4dwt_pkg::TAPS];
    int                            line_pos;
    logic [db4dwt_pkg::HALF_W-1:0] half_reg;

    t_coef_pair expected_pairs[$];
    int         errors;
    int         in_idle_pct;
    int         out_stall_pct;
    int         hold_left;
    int         cycle_count = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    // db4 low-pass taps, Q2.30
    function automatic longint lowpass_q30(input int k);
        case (k)
            0: return 64'sd247366293;
            1: return 64'sd767560661;
            2: return 64'sd677403066;
            3: return -64'sd30047344;
            4: return -64'sd200827100;
            5: return 64'sd33115682;
            6: return 64'sd35307854;
            default: return -64'sd11378874;
        endcase
    endfunction

    // Round to nearest, ties away from zero
    function automatic longint round_near(input longint v, input int s);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (s - 1))) >>> s;
        return (v < 0) ? -m : m;
    endfunction

    // g[k] = (-1)^k * h[7-k]
    function automatic longint tap_coef(input int k, input bit high);
        longint c;
        if (high) begin
            c = lowpass_q30(db4dwt_pkg::TAPS - 1 - k);
            if (k % 2 == 1) c = -c;
        end else begin
            c = lowpass_q30(k);
        end
        return round_near(c, 30 - db4dwt_pkg::COEF_FRAC);
    endfunction

    function automatic longint clamp_out(input longint v);
        if (v > db4dwt_pkg::OUT_MAX) return db4dwt_pkg::OUT_MAX;
        if (v < db4dwt_pkg::OUT_MIN) return db4dwt_pkg::OUT_MIN;
        return v;
    endfunction

    // Register value to pairs per line: zero counts as one, large values clip
    function automatic int effective_half(input logic [db4dwt_pkg::HALF_W-1:0] v);
        if (v == 0) return 1;
        if (int'(v) > db4dwt_pkg::MAX_HALF) return db4dwt_pkg::MAX_HALF;
        return int'(v);
    endfunction

    // Filter the eight samples in tap_sel into one pair
    function automatic t_coef_pair filter_pair(input int i, input int half);
        longint     acc_lo;
        longint     acc_hi;
        longint     lo_v;
        longint     hi_v;
        t_coef_pair r;
        acc_lo = 0;
        acc_hi = 0;
        for (int k = 0; k < db4dwt_pkg::TAPS; k++) begin
            acc_lo += tap_coef(k, 1'b0) * tap_sel[k];
            acc_hi += tap_coef(k, 1'b1) * tap_sel[k];
        end
        lo_v = clamp_out(round_near(acc_lo, db4dwt_pkg::COEF_FRAC));
        hi_v = clamp_out(round_near(acc_hi, db4dwt_pkg::COEF_FRAC));
        r.approx   = lo_v[db4dwt_pkg::OUT_W-1:0];
        r.detail   = hi_v[db4dwt_pkg::OUT_W-1:0];
        r.idx      = i[db4dwt_pkg::IDX_W-1:0];
        r.line_end = (i == half - 1);
        return r;
    endfunction

    // Advance the line model by one accepted sample, queue the pairs it yields
    task automatic predict_sample(input db4dwt_pkg::t_sample s);
        int half;
        int len;
        int p;
        int q;
        int i0;
        half = effective_half(half_reg);
        len  = 2 * half;
        p    = line_pos;
        if (p >= len) p = 0;
        if (p < db4dwt_pkg::HEAD_DEPTH) head_q[p] = longint'(s);
        for (int k = 0; k < db4dwt_pkg::TAPS - 1; k++) win_q[k] = win_q[k + 1];
        win_q[db4dwt_pkg::TAPS - 1] = longint'(s);

        if (p == len - 1) begin
            // last sample: wrapped pairs, taps read from head and window
            i0 = (half >= 4) ? half - 4 : 0;
            for (int i = i0; i < half; i++) begin
                for (int k = 0; k < db4dwt_pkg::TAPS; k++) begin
                    q = (2 * i + k) % len;
                    tap_sel[k] = (q < db4dwt_pkg::HEAD_DEPTH) ? head_q[q]
                               : win_q[(q + db4dwt_pkg::TAPS - len) & 7];
                end
                expected_pairs = {expected_pairs, filter_pair(i, half)};
            end
            line_pos = 0;
        end else begin
            if ((p % 2 == 1) && p >= db4dwt_pkg::FIRST_POS) begin
                for (int k = 0; k < db4dwt_pkg::TAPS; k++) tap_sel[k] = win_q[k];
                expected_pairs = {expected_pairs,
                                  filter_pair((p - db4dwt_pkg::FIRST_POS) / 2, half)};
            end
            line_pos = p + 1;
        end
    endtask

    // Send one sample; called right after a rising edge
    task automatic send_sample(input db4dwt_pkg::t_sample s);
        logic rdy;
        while ($urandom_range(99) < in_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= s;
        do begin
            @(negedge i_clk);
            rdy = in_if.ready;
            @(posedge i_clk);
        end while (!rdy);
        predict_sample(s);
    endtask

    // Stop sending and wait until every pair is out and the pipe is quiet
    task automatic settle();
        in_if.valid <= 1'b0;
        while (expected_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_half(input logic [db4dwt_pkg::HALF_W-1:0] v);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        half_reg = v;
        line_pos = 0;
    endtask

    function automatic db4dwt_pkg::t_sample rand_sample();
        int r;
        r = $urandom_range(99);
        if (r < 4) return SMAX;
        if (r < 8) return SMIN;
        if (r < 11) return '0;
        if (r < 14) return '1;
        return db4dwt_pkg::t_sample'($urandom());
    endfunction

    // Receiver: random stalls, or a counted hold-off when requested
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99) >= out_stall_pct);
            end
        end
    end

    task automatic check_field(input string fname, input longint want, input longint got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // Checker: output item accepted at the next edge when valid and ready
    initial begin
        t_coef_pair want;
        forever begin
            @(negedge i_clk);
            if (i_rst_n && out_if.valid && out_if.ready) begin
                if (expected_pairs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pair, expected none, actual idx %0d approx %0d",
                             $time, out_if.pair_index, $signed(out_if.approx));
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("approx", $signed(want.approx), $signed(out_if.approx));
                    check_field("detail", $signed(want.detail), $signed(out_if.detail));
                    check_field("pair_index", want.idx, out_if.pair_index);
                    check_field("line_end", want.line_end, out_if.line_end);
                end
            end
        end
    end

    // Extremes, zero and short lines, and a restart in mid-line
    task automatic test_directed();
        db4dwt_pkg::t_sample peak_line[16] = '{SMAX, SMAX, SMAX, SMIN, SMIN, SMAX, SMAX,
                                               SMIN, SMIN, SMIN, SMIN, SMAX, SMAX, SMIN,
                                               SMIN, SMAX};
        db4dwt_pkg::t_sample quad_line[4]  = '{SMAX, -24'sd1, SMIN, 24'sd0};
        in_idle_pct   = 0;
        out_stall_pct = 0;
        // default register: eight pairs
        foreach (peak_line[j]) send_sample(peak_line[j]);
        // zero means a two-sample line
        write_half('0);
        send_sample(24'sd0);
        send_sample(-24'sd1);
        // short line, taps wrap more than once
        write_half(12'd2);
        foreach (quad_line[j]) send_sample(quad_line[j]);
        // partial line, cut off by the next write
        write_half(12'd4);
        send_sample(24'sd1);
        send_sample(-24'sd2);
        send_sample(SMAX);
    endtask

    // Largest register values and saturating writes, each line cut short
    task automatic test_longest_line();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_half('1);
        repeat (20) send_sample(rand_sample());
        write_half(12'd2049);
        repeat (20) send_sample(rand_sample());
        write_half(12'd2048);
        repeat (20) send_sample(rand_sample());
    endtask

    // Random lines: mostly whole lines of small size, some cut short
    task automatic test_random_lines(input int budget, input int in_pct, input int out_pct);
        int                            sent;
        int                            r;
        int                            h;
        int                            len;
        int                            n;
        logic [db4dwt_pkg::HALF_W-1:0] v;
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        sent = 0;
        while (sent < budget) begin
            r = $urandom_range(99);
            if (r < 4)       v = '0;
            else if (r < 8)  v = db4dwt_pkg::t_half'($urandom_range(2049, 4095));
            else if (r < 70) v = db4dwt_pkg::t_half'($urandom_range(1, 6));
            else if (r < 90) v = db4dwt_pkg::t_half'($urandom_range(7, 16));
            else             v = db4dwt_pkg::t_half'($urandom_range(17, 40));
            write_half(v);
            h   = effective_half(v);
            len = 2 * h;
            if (h > 40)
                n = $urandom_range(1, 30);
            else if ($urandom_range(99) < 15)
                n = $urandom_range(1, len - 1);
            else
                n = len * $urandom_range(1, 2);
            repeat (n) begin
                send_sample(rand_sample());
                sent++;
            end
        end
    endtask

    // Long receiver hold-off while samples keep coming, then a full drain
    task automatic test_output_hold_off();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        write_half(12'd8);
        @(negedge i_clk);
        hold_left = 300;
        @(posedge i_clk);
        repeat (64) send_sample(rand_sample());
        settle();
        repeat (20) send_sample(rand_sample());
    endtask

    initial begin
        errors        = 0;
        hold_left     = 0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        half_reg      = db4dwt_pkg::t_half'(db4dwt_pkg::HALF_RESET);
        line_pos      = 0;
        foreach (head_q[k]) head_q[k] = 0;
        foreach (win_q[k]) win_q[k] = 0;

        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        in_if.valid   <= 1'b0;
        in_if.sample  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_longest_line();
        test_random_lines(60, 0, 0);
        test_random_lines(60, 47, 0);
        test_random_lines(60, 0, 47);
        test_random_lines(60, 24, 24);
        test_output_hold_off();
        settle();

        if (errors == 0 && expected_pairs.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
